>>> sv/scrc_pkg.sv
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared types and constants of the sensor channel reading converter.
// ----------------------------------------------------------------------------
package scrc_pkg;

    localparam int          MAX_SLOTS   = 8;
    localparam int          ID_W        = 16;
    localparam int          VAL_W       = 32;
    localparam int          NUMER_W     = 64;
    localparam int          QUO_BITS    = 31;
    localparam int          CNT_W       = 5;
    localparam int          MS_W        = 22;
    localparam int          PROD_W      = VAL_W + MS_W;
    localparam logic [31:0] MS_PER_HOUR = 32'd3600000;

    // unit codes of slot_units
    localparam logic [1:0] UNIT_OFF      = 2'd0;
    localparam logic [1:0] UNIT_HUMIDITY = 2'd1;
    localparam logic [1:0] UNIT_TENTH_C  = 2'd2;
    localparam logic [1:0] UNIT_ENERGY   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_IDS_LOW   = 3'd0;
    localparam logic [2:0] CFG_IDS_HIGH  = 3'd1;
    localparam logic [2:0] CFG_UNITS     = 3'd2;
    localparam logic [2:0] CFG_IVL_EN    = 3'd3;
    localparam logic [2:0] CFG_INTERVALS = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic               start;
        logic [NUMER_W-1:0] numer;
        logic [VAL_W-1:0]   denom;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/scrc_ram.sv
// ----------------------------------------------------------------------------
// scrc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scrc_ram #(
    parameter int  WIDTH = 96,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/scrc_div.sv
// ----------------------------------------------------------------------------
// scrc_div
// Bit-serial restoring divider, saturating to a 31-bit positive quotient.
// ----------------------------------------------------------------------------
module scrc_div
    import scrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [VAL_W-1:0]    rem_reg;
    logic [QUO_BITS-1:0] low_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [VAL_W:0]   trial;
    logic             fits;
    logic [VAL_W:0]   head;
    logic             sat;

    // quotient overflows 31 bits exactly when the upper numerator part reaches denom
    assign head  = req.numer[NUMER_W-1:QUO_BITS];
    assign sat   = head >= {1'b0, req.denom};
    assign trial = {rem_reg, low_reg[QUO_BITS-1]};
    assign fits  = trial >= {1'b0, req.denom};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (sat) begin
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= head[VAL_W-1:0];
                    low_reg  <= req.numer[QUO_BITS-1:0];
                    cnt_reg  <= CNT_W'(QUO_BITS);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= VAL_W'(trial - {1'b0, req.denom});
                end else begin
                    rem_reg <= trial[VAL_W-1:0];
                end
                low_reg <= {low_reg[QUO_BITS-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = {1'b0, quo_reg};

endmodule

>>> sv/sensor_channel_reading_converter_unit.sv
// ----------------------------------------------------------------------------
// sensor_channel_reading_converter_unit
// Matches a channel record to a slot, applies the slot's report interval and
// converts the reading; energy slots yield power from count and clock deltas.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_       | in        | s_valid / s_ready | channel_id, raw_value, sample_clock, now_seconds
//  m_       | out       | m_valid / m_ready | slot_index, channel_out, unit_kind, reading
//  cfg_     | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
//  One word is in work at a time. An unknown id is dropped without leaving the
//  idle state, a dropped or pass-through word goes through the slot lookup, and
//  a power word through the serial divider: one quotient bit per cycle over 31 bits.
//  Slot state sits in one RAM read in the accept cycle; per-slot valid flops
//  are cleared by reset, so no clearing pass is needed.
//  The output register holds one result; a further result waits until it is taken.
// ----------------------------------------------------------------------------
module sensor_channel_reading_converter_unit
    import scrc_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_channel_id,
    input  logic signed [31:0] s_raw_value,
    input  logic [31:0]       s_sample_clock,
    input  logic [31:0]       s_now_seconds,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_slot_index,
    output logic [15:0]       m_channel_out,
    output logic [1:0]        m_unit_kind,
    output logic signed [31:0] m_reading
);

    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = 3 * VAL_W;

    // configuration
    logic [63:0] ids_low_reg;
    logic [63:0] ids_high_reg;
    logic [15:0] units_reg;
    logic [7:0]  ivl_en_reg;
    logic [63:0] intervals_reg;

    state_t state_reg;
    state_t state_next;

    logic [2:0]       slot_reg;
    logic [1:0]       unit_reg;
    logic [15:0]      chan_reg;
    logic [31:0]      raw_reg;
    logic [31:0]      clk_reg;
    logic [31:0]      now_reg;
    logic [31:0]      dcount_reg;
    logic [31:0]      dt_reg;
    logic [PROD_W-1:0] product_reg;
    logic [31:0]      result_reg;

    logic             m_valid_reg;
    logic [2:0]       m_slot_reg;
    logic [15:0]      m_chan_reg;
    logic [1:0]       m_unit_reg;
    logic [31:0]      m_reading_reg;

    logic             seen_reg   [SLOTS];
    logic             na_vld_reg [SLOTS];

    logic [7:0][15:0] slot_ids;
    logic [7:0][1:0]  slot_units;
    logic [7:0][7:0]  slot_gaps;

    logic             accept;
    logic             match_found;
    logic [2:0]       match_slot;

    logic [AW-1:0]      slot_addr;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ENTRY_W-1:0] wr_entry;
    logic [31:0]        old_na;
    logic [31:0]        old_count;
    logic [31:0]        old_clock;
    logic [31:0]        new_na;
    logic [31:0]        dcount;
    logic [31:0]        dt;
    logic               ivl_on;
    logic               pass;
    logic               is_energy;
    logic               emit_power;
    logic               ram_wr_en;
    logic               out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign slot_ids   = {ids_high_reg, ids_low_reg};
    assign slot_units = units_reg;
    assign slot_gaps  = intervals_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // lowest active slot with this id wins
    always_comb begin
        match_found = 1'b0;
        match_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_units[i] != UNIT_OFF && slot_ids[i] == s_channel_id) begin
                match_found = 1'b1;
                match_slot  = 3'(i);
            end
        end
    end

    assign slot_addr = slot_reg[AW-1:0];

    assign old_na    = na_vld_reg[slot_addr] ? rd_entry[3*VAL_W-1:2*VAL_W] : '0;
    assign old_count = rd_entry[2*VAL_W-1:VAL_W];
    assign old_clock = rd_entry[VAL_W-1:0];
    assign ivl_on    = ivl_en_reg[slot_reg];
    assign pass      = !(ivl_on && (old_na > now_reg));
    assign new_na    = ivl_on ? (now_reg + 32'(slot_gaps[slot_reg])) : old_na;
    assign is_energy = (unit_reg == UNIT_ENERGY);
    assign dcount    = raw_reg - old_count;
    assign dt        = clk_reg - old_clock;
    assign emit_power = seen_reg[slot_addr] && (dt != '0) && (dt < MS_PER_HOUR);

    assign ram_wr_en = (state_reg == ST_LOOK) && pass;
    assign wr_entry  = is_energy ? {new_na, raw_reg, clk_reg}
                                 : {new_na, old_count, old_clock};

    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    scrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_addr),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (match_slot[AW-1:0]),
        .rd_data (rd_entry)
    );

    assign div_req.start = (state_reg == ST_START);
    assign div_req.numer = NUMER_W'(product_reg);
    assign div_req.denom = dt_reg;

    scrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && match_found) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!pass) begin
                    state_next = ST_IDLE;
                end else if (!is_energy) begin
                    state_next = ST_OUT;
                end else if (emit_power) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            ids_low_reg   <= '0;
            ids_high_reg  <= '0;
            units_reg     <= '0;
            ivl_en_reg    <= '0;
            intervals_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                seen_reg[i]   <= 1'b0;
                na_vld_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IDS_LOW:   ids_low_reg   <= cfg_wdata;
                    CFG_IDS_HIGH:  ids_high_reg  <= cfg_wdata;
                    CFG_UNITS:     units_reg     <= cfg_wdata[15:0];
                    CFG_IVL_EN:    ivl_en_reg    <= cfg_wdata[7:0];
                    CFG_INTERVALS: intervals_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (ram_wr_en) begin
                na_vld_reg[slot_addr] <= 1'b1;
                if (is_energy) begin
                    seen_reg[slot_addr] <= 1'b1;
                end
            end

            // drop the held word once taken, unless a new one replaces it
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= match_slot;
            unit_reg <= slot_units[match_slot];
            chan_reg <= s_channel_id;
            raw_reg  <= s_raw_value;
            clk_reg  <= s_sample_clock;
            now_reg  <= s_now_seconds;
        end
        if (state_reg == ST_LOOK) begin
            dcount_reg <= dcount;
            dt_reg     <= dt;
            result_reg <= raw_reg;
        end
        if (state_reg == ST_MUL) begin
            product_reg <= PROD_W'(dcount_reg) * PROD_W'(MS_PER_HOUR);
        end
        if (state_reg == ST_DIV && div_rsp.done) begin
            result_reg <= div_rsp.quotient;
        end
        if (out_load) begin
            m_slot_reg    <= slot_reg;
            m_chan_reg    <= chan_reg;
            m_unit_reg    <= unit_reg;
            m_reading_reg <= result_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_index  = m_slot_reg;
    assign m_channel_out = m_chan_reg;
    assign m_unit_kind   = m_unit_reg;
    assign m_reading     = m_reading_reg;

    // assertions

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("pending result left before the output register freed");

    a_power_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_unit_reg == UNIT_ENERGY) |-> !m_reading_reg[31])
        else $error("power reading not saturated to a positive value");

    a_look_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> $past(accept))
        else $error("slot lookup without an accepted word");

endmodule

>>> dv/sensor_channel_reading_converter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_channel_reading_converter_unit_test
// Sends channel records through the converter with random idle cycles on both
// sides. A local copy of the slot state predicts every reading: slot match,
// report interval and meter power. Results are compared field by field in
// arrival order. Directed cases come first, then random traffic over several
// slot layouts.
// ----------------------------------------------------------------------------
module sensor_channel_reading_converter_unit_test
    import scrc_pkg::*;
();

    localparam logic [2:0] CFG_SPARE       = 3'd7;  // index past the last register
    localparam int         TAIL_CYCLES     = 64;
    localparam int         DRAIN_LIMIT     = 20000;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         WORDS_PER_PHASE = 145;
    localparam int         TIMEOUT_NS      = 5_000_000;

    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] chan;
        logic [1:0]  unit;
        logic [31:0] value;
    } reading_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [2:0]  cfg_index      = '0;
    logic [63:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [15:0] s_channel_id   = '0;
    logic [31:0] s_raw_value    = '0;
    logic [31:0] s_sample_clock = '0;
    logic [31:0] s_now_seconds  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_slot_index;
    logic [15:0] m_channel_out;
    logic [1:0]  m_unit_kind;
    logic [31:0] m_reading;

    // layout copy
    logic [63:0] ids_lo;
    logic [63:0] ids_hi;
    logic [15:0] units;
    logic [7:0]  ivl_en;
    logic [63:0] ivls;

    // per-slot state copy
    logic [31:0] meter_count [8];
    logic [31:0] meter_clock [8];
    logic        meter_seen  [8];
    logic [31:0] next_ok     [8];

    reading_t    pending_readings [$];
    int          fail_count = 0;
    bit          burst_mode = 1'b0;
    logic [31:0] wall = '0;

    sensor_channel_reading_converter_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel_id   (s_channel_id),
        .s_raw_value    (s_raw_value),
        .s_sample_clock (s_sample_clock),
        .s_now_seconds  (s_now_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_index   (m_slot_index),
        .m_channel_out  (m_channel_out),
        .m_unit_kind    (m_unit_kind),
        .m_reading      (m_reading)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] slot_id(input int i);
        if (i < 4) begin
            return ids_lo[16*i +: 16];
        end
        return ids_hi[16*(i-4) +: 16];
    endfunction

    // lowest active slot with this id, or -1
    function automatic int match_slot(input logic [15:0] id);
        for (int i = 0; i < 8; i++) begin
            if (units[2*i +: 2] != UNIT_OFF && slot_id(i) == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit convert_record(input logic [15:0] id, input logic [31:0] raw,
                                          input logic [31:0] clk, input logic [31:0] now,
                                          output reading_t r);
        int          s;
        logic [1:0]  unit;
        logic [31:0] dcount;
        logic [31:0] dt;
        logic [63:0] power;
        bit          had;
        r = '0;
        s = match_slot(id);
        if (s < 0) begin
            return 0;
        end
        unit = units[2*s +: 2];
        if (ivl_en[s]) begin
            if (next_ok[s] > now) begin
                return 0;
            end
            next_ok[s] = now + ivls[8*s +: 8];
        end
        r.slot  = s[2:0];
        r.chan  = id;
        r.unit  = unit;
        r.value = raw;
        if (unit == UNIT_ENERGY) begin
            dcount = raw - meter_count[s];
            dt     = clk - meter_clock[s];
            had    = meter_seen[s];
            meter_count[s] = raw;
            meter_clock[s] = clk;
            meter_seen[s]  = 1'b1;
            if (!had || dt == 32'd0 || dt >= MS_PER_HOUR) begin
                return 0;
            end
            power   = ({32'd0, MS_PER_HOUR} * {32'd0, dcount}) / {32'd0, dt};
            r.value = (power > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : power[31:0];
        end
        return 1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected reading: slot %0d channel %h reading %h",
                       m_slot_index, m_channel_out, m_reading);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("slot_index", 32'(want.slot), 32'(m_slot_index));
                check_field("channel_out", 32'(want.chan), 32'(m_channel_out));
                check_field("unit_kind", 32'(want.unit), 32'(m_unit_kind));
                check_field("reading", want.value, m_reading);
            end
        end
    end

    // result side: stall before each word
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_record(input logic [15:0] id, input logic [31:0] raw,
                               input logic [31:0] clk, input logic [31:0] now);
        int       gap;
        reading_t r;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_channel_id   <= id;
        s_raw_value    <= raw;
        s_sample_clock <= clk;
        s_now_seconds  <= now;
        do @(posedge aclk); while (!s_ready);
        if (convert_record(id, raw, clk, now, r)) begin
            pending_readings.push_back(r);
        end
    endtask

    // drop valid, wait for outstanding readings, then hold for tail cycles
    task automatic settle(input int tail);
        int n;
        n = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            n++;
        end while (pending_readings.size() != 0 && n < DRAIN_LIMIT);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_IDS_LOW:   ids_lo = data;
            CFG_IDS_HIGH:  ids_hi = data;
            CFG_UNITS:     units  = data[15:0];
            CFG_IVL_EN:    ivl_en = data[7:0];
            CFG_INTERVALS: ivls   = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_layout(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] u, input logic [7:0] en,
                               input logic [63:0] iv);
        settle(TAIL_CYCLES);
        write_reg(CFG_IDS_LOW, lo);
        write_reg(CFG_IDS_HIGH, hi);
        write_reg(CFG_UNITS, {48'd0, u});
        write_reg(CFG_IVL_EN, {56'd0, en});
        write_reg(CFG_INTERVALS, iv);
    endtask

    // slot0 id 0 humidity, slot1 FFFF tenths, slots 2/3 share 1234 (energy wins),
    // slot4 off and slot5 share 00AA, slot6 5555 energy, slot7 FFFF shadowed by slot1
    task automatic load_directed_layout();
        load_layout(64'h1234_1234_FFFF_0000, 64'hFFFF_5555_00AA_00AA,
                    {UNIT_ENERGY, UNIT_ENERGY, UNIT_HUMIDITY, UNIT_OFF,
                     UNIT_HUMIDITY, UNIT_ENERGY, UNIT_TENTH_C, UNIT_HUMIDITY},
                    8'b0100_0001, 64'h000A_0000_0050_00FF);
    endtask

    task automatic test_reset_state();
        // every slot is off after reset
        send_record(16'h0000, 32'd5, 32'd0, 32'd0);
        load_layout('0, '0, '0, '0, '0);
    endtask

    task automatic test_pass_through();
        load_directed_layout();
        send_record(16'hFFFF, 32'h8000_0000, 32'd1, 32'd0);
        send_record(16'hFFFF, 32'h7FFF_FFFF, 32'd2, 32'd0);
        send_record(16'h00AA, 32'hFFFF_FFFF, 32'd3, 32'd0);
        send_record(16'h4321, 32'd77, 32'd4, 32'd0);
    endtask

    task automatic test_energy_meter();
        logic [31:0] t;
        t = 32'hFFFF_F000;
        send_record(16'h1234, 32'd1000, t, 32'd0);
        t = 32'h0000_03E8;  // clock wraps
        send_record(16'h1234, 32'd2000, t, 32'd0);
        send_record(16'h1234, 32'd2000, t, 32'd0);
        t = t + 32'd3599999;
        send_record(16'h1234, 32'd2500, t, 32'd0);
        t = t + MS_PER_HOUR;
        send_record(16'h1234, 32'd3000, t, 32'd0);
        t = t + 32'd1;
        send_record(16'h1234, 32'd4000, t, 32'd0);
        t = t + 32'd3599999;
        send_record(16'h1234, 32'd10, t, 32'd0);
    endtask

    task automatic test_report_interval();
        send_record(16'h0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_record(16'h0000, 32'h8000_0000, 32'd0, 32'h10);
        send_record(16'h0000, 32'hFFFF_FFFF, 32'd0, 32'hFF);
        // next allowed time wraps past zero
        send_record(16'h0000, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_record(16'h0000, 32'd1, 32'd0, 32'd5);
        send_record(16'h5555, 32'd7, 32'd0, 32'd100);
        send_record(16'h5555, 32'd9, 32'd500, 32'd105);
        send_record(16'h5555, 32'd9, 32'd500, 32'd110);
    endtask

    task automatic test_spare_register();
        settle(TAIL_CYCLES);
        write_reg(CFG_SPARE, '1);
        send_record(16'hFFFF, 32'd215, 32'd0, 32'd0);
    endtask

    task automatic load_random_layout();
        logic [15:0] pool [4];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] iv;
        logic [15:0] id;
        for (int i = 0; i < 4; i++) begin
            pool[i] = 16'($urandom);
        end
        for (int i = 0; i < 8; i++) begin
            id = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 3)] : 16'($urandom);
            if (i < 4) begin
                lo[16*i +: 16] = id;
            end else begin
                hi[16*(i-4) +: 16] = id;
            end
            iv[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 3));
        end
        load_layout(lo, hi, 16'($urandom),
                    $urandom_range(0, 1) ? 8'($urandom) : 8'h00, iv);
    endtask

    task automatic drive_random_record();
        int          s;
        logic [15:0] id;
        logic [31:0] raw;
        logic [31:0] clk;
        id = ($urandom_range(0, 6) == 0) ? 16'($urandom) : slot_id($urandom_range(0, 7));
        s  = match_slot(id);
        if ($urandom_range(0, 39) == 0) begin
            wall = $urandom;
        end else begin
            wall = wall + $urandom_range(0, 3);
        end
        // mostly plausible meter sequences so power gets computed
        if (s >= 0 && units[2*s +: 2] == UNIT_ENERGY && $urandom_range(0, 4) != 0) begin
            raw = meter_count[s] + (($urandom_range(0, 7) == 0) ? $urandom
                                                                : $urandom_range(0, 20000));
            clk = meter_clock[s] + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000000)
                                                                : $urandom_range(1, 400000));
        end else begin
            raw = $urandom;
            clk = $urandom;
        end
        send_record(id, raw, clk, wall);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                load_layout('1, '1, '1, '1, '1);
            end else begin
                load_random_layout();
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (k % 50 == 0) begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                end
                if (k == 100) begin
                    settle(0);  // hold the sender until every reading is out
                end
                drive_random_record();
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        ids_lo = '0;
        ids_hi = '0;
        units  = '0;
        ivl_en = '0;
        ivls   = '0;
        for (int i = 0; i < 8; i++) begin
            meter_count[i] = '0;
            meter_clock[i] = '0;
            meter_seen[i]  = 1'b0;
            next_ok[i]     = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_pass_through();
        test_energy_meter();
        test_report_interval();
        test_spare_register();
        test_random_traffic();

        settle(TAIL_CYCLES);
        if (pending_readings.size() != 0) begin
            $error("%0d expected readings never arrived", pending_readings.size());
            fail_count += pending_readings.size();
        end
        if (fail_count == 0) begin
            $display("sensor_channel_reading_converter_unit verification clean");
        end else begin
            $display("sensor_channel_reading_converter_unit verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sensor_channel_reading_converter_unit verification failed");
        $finish;
    end

endmodule
